// ----- hw/rtl/plmc_pkg.sv -----
package plmc_pkg;

  localparam logic [31:0] MAGIC_WORD   = 32'h594D444D;
  localparam logic [15:0] VERSION_WORD = 16'd1;
  localparam logic [32:0] HEADER_BYTES = 33'd12;
  localparam logic [32:0] OFFSET_MAX   = 33'h1FFFFFFFF;

  localparam logic [15:0] PATH_LIMIT_RST    = 16'd256;
  localparam logic [31:0] PAYLOAD_LIMIT_RST = 32'd65536;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [7:0] {
    REG_PATH_LIMIT    = 8'd0,
    REG_PAYLOAD_LIMIT = 8'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_HEAD  = 3'd0,
    PH_LEN0  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LEN2  = 3'd3,
    PH_LEN3  = 3'd4,
    PH_TEXT  = 3'd5,
    PH_TAIL  = 3'd6,
    PH_DRAIN = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    ERR_OK       = 4'd0,
    ERR_SHORT    = 4'd1,
    ERR_MAGIC    = 4'd2,
    ERR_VERSION  = 4'd3,
    ERR_COUNT    = 4'd4,
    ERR_PAYLOAD  = 4'd5,
    ERR_SIZE     = 4'd6,
    ERR_ODD      = 4'd7,
    ERR_OVERRUN  = 4'd8,
    ERR_TRAILING = 4'd9
  } err_t;

  typedef enum logic [1:0] {
    KIND_UNIT    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] code_unit;
    logic        path_done;
    logic [15:0] path_number;
    err_t        error_code;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [QUEUE_AW:0] count;
    logic              room2;
  } queue_status_t;

endpackage

// ----- hw/rtl/path_list_message_checker_core.sv -----
// A result item enters the result queue at the clock edge on which its byte is accepted.
// Throughput: one byte per cycle while the queue has two free entries; the parser updates
// per byte, and a four-entry result queue absorbs the final byte's extra verdict item.
// Bytes are taken whenever the result queue has two free entries.
// Reset (rst, synchronous): parser state returns to the header phase, the queue empties,
// path_limit resets to 256 and payload_limit to 65536.
module path_list_message_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] code_unit, [31:16] path_number,
                                      // [35:32] error_code, [39:36] zero
  output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] path_done
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0] path_limit;
  logic [31:0] payload_limit;
  logic        in_accept;
  logic [1:0]  res_count;
  plmc_pkg::result_t [1:0]  res;
  plmc_pkg::result_t        out_data;
  plmc_pkg::queue_status_t  qstat;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = qstat.room2;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_limit    <= plmc_pkg::PATH_LIMIT_RST;
      payload_limit <= plmc_pkg::PAYLOAD_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        plmc_pkg::REG_PATH_LIMIT:    path_limit    <= cfg_data[15:0];
        plmc_pkg::REG_PAYLOAD_LIMIT: payload_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  plmc_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .data_byte      (s_axis_tdata),
    .end_of_message (s_axis_tlast),
    .path_limit     (path_limit),
    .payload_limit  (payload_limit),
    .res_count      (res_count),
    .res            (res)
  );

  plmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (res_count),
    .push_data  (res),
    .pop        (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_data   (out_data),
    .status     (qstat)
  );

  assign m_axis_tdata = {4'd0, out_data.error_code, out_data.path_number, out_data.code_unit};
  assign m_axis_tuser = {out_data.path_done, out_data.kind};
  assign m_axis_tlast = out_data.last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= (plmc_pkg::QUEUE_AW + 1)'(plmc_pkg::QUEUE_DEPTH))
    else $error("result queue over capacity");

  a_verdict_queued: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tlast) |=> m_axis_tvalid)
    else $error("final byte left no verdict pending");

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1:0] == plmc_pkg::KIND_VERDICT) |->
      (m_axis_tlast && !m_axis_tuser[2]))
    else $error("verdict item not closing its run");

endmodule

// ----- hw/rtl/plmc_parser.sv -----
module plmc_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                data_byte,
  input  logic                      end_of_message,
  input  logic [15:0]               path_limit,
  input  logic [31:0]               payload_limit,
  output logic [1:0]                res_count,
  output plmc_pkg::result_t [1:0]   res
);

  plmc_pkg::phase_t phase, phase_step, phase_next;
  logic [32:0] byte_offset, byte_offset_step, byte_offset_next;
  logic [63:0] header_store, header_store_step, header_store_next;
  logic [31:0] declared_payload, declared_payload_step, declared_payload_next;
  logic [15:0] declared_count, declared_count_step, declared_count_next;
  logic [15:0] paths_seen, paths_seen_step, paths_seen_next;
  logic [31:0] record_remaining, record_remaining_step, record_remaining_next;
  logic [7:0]  low_byte_hold, low_byte_hold_step, low_byte_hold_next;
  plmc_pkg::err_t first_error, first_error_step, first_error_next;

  logic [32:0] end_ofs;
  logic [31:0] len_full;
  logic [31:0] payload_full;
  logic        len0_over;
  logic        len3_over;
  logic        hdr_last;
  logic [15:0] ps_inc;
  plmc_pkg::phase_t close_phase;
  logic [31:0] rr_dec;
  logic        text_low;
  logic        text_done;
  logic [32:0] end_step;
  plmc_pkg::err_t verdict;
  plmc_pkg::result_t prim, vres;
  logic        prim_valid;

  assign end_ofs      = plmc_pkg::HEADER_BYTES + {1'b0, declared_payload};
  assign len_full     = {data_byte, record_remaining[23:0]};
  assign payload_full = {data_byte, declared_payload[23:0]};
  assign len0_over    = ({1'b0, byte_offset} + 34'd4) > {1'b0, end_ofs};
  assign len3_over    = ({1'b0, byte_offset} + 34'd1 + {2'b00, len_full}) > {1'b0, end_ofs};
  assign hdr_last     = (byte_offset[3:0] == 4'd11);
  assign ps_inc       = paths_seen + 16'd1;
  assign close_phase  = (ps_inc == declared_count) ? plmc_pkg::PH_TAIL : plmc_pkg::PH_LEN0;
  assign rr_dec       = record_remaining - 32'd1;
  assign text_low     = ~record_remaining[0];
  assign text_done    = (rr_dec == 32'd0);

  // next state: one byte step, then clear on the final byte
  always_comb begin
    phase_step            = phase;
    header_store_step     = header_store;
    declared_payload_step = declared_payload;
    declared_count_step   = declared_count;
    paths_seen_step       = paths_seen;
    record_remaining_step = record_remaining;
    low_byte_hold_step    = low_byte_hold;
    first_error_step      = first_error;
    byte_offset_step      = (byte_offset == plmc_pkg::OFFSET_MAX) ? byte_offset
                                                                  : byte_offset + 33'd1;
    case (phase)
      plmc_pkg::PH_HEAD: begin
        if (!byte_offset[3]) begin
          header_store_step[{byte_offset[2:0], 3'b000} +: 8] = data_byte;
        end else begin
          declared_payload_step[{byte_offset[1:0], 3'b000} +: 8] = data_byte;
        end
        if (hdr_last) begin
          if (header_store[31:0] != plmc_pkg::MAGIC_WORD) begin
            first_error_step = plmc_pkg::ERR_MAGIC;
            phase_step       = plmc_pkg::PH_DRAIN;
          end else if (header_store[47:32] != plmc_pkg::VERSION_WORD) begin
            first_error_step = plmc_pkg::ERR_VERSION;
            phase_step       = plmc_pkg::PH_DRAIN;
          end else if (header_store[63:48] > path_limit) begin
            first_error_step = plmc_pkg::ERR_COUNT;
            phase_step       = plmc_pkg::PH_DRAIN;
          end else if (payload_full > payload_limit) begin
            first_error_step = plmc_pkg::ERR_PAYLOAD;
            phase_step       = plmc_pkg::PH_DRAIN;
          end else begin
            declared_count_step = header_store[63:48];
            paths_seen_step     = 16'd0;
            phase_step          = (header_store[63:48] != 16'd0) ? plmc_pkg::PH_LEN0
                                                                 : plmc_pkg::PH_TAIL;
          end
        end
      end
      plmc_pkg::PH_LEN0: begin
        if (len0_over) begin
          first_error_step = plmc_pkg::ERR_OVERRUN;
          phase_step       = plmc_pkg::PH_DRAIN;
        end else begin
          record_remaining_step = {24'd0, data_byte};
          phase_step            = plmc_pkg::PH_LEN1;
        end
      end
      plmc_pkg::PH_LEN1: begin
        record_remaining_step[15:8] = data_byte;
        phase_step                  = plmc_pkg::PH_LEN2;
      end
      plmc_pkg::PH_LEN2: begin
        record_remaining_step[23:16] = data_byte;
        phase_step                   = plmc_pkg::PH_LEN3;
      end
      plmc_pkg::PH_LEN3: begin
        if (len_full[0]) begin
          first_error_step = plmc_pkg::ERR_ODD;
          phase_step       = plmc_pkg::PH_DRAIN;
        end else if (len3_over) begin
          first_error_step = plmc_pkg::ERR_OVERRUN;
          phase_step       = plmc_pkg::PH_DRAIN;
        end else if (len_full == 32'd0) begin
          paths_seen_step = ps_inc;
          phase_step      = close_phase;
        end else begin
          record_remaining_step = len_full;
          phase_step            = plmc_pkg::PH_TEXT;
        end
      end
      plmc_pkg::PH_TEXT: begin
        record_remaining_step = rr_dec;
        if (text_low) begin
          low_byte_hold_step = data_byte;
        end else if (text_done) begin
          paths_seen_step = ps_inc;
          phase_step      = close_phase;
        end
      end
      plmc_pkg::PH_TAIL: begin
        first_error_step = plmc_pkg::ERR_TRAILING;
        phase_step       = plmc_pkg::PH_DRAIN;
      end
      default: begin
      end
    endcase

    if (end_of_message) begin
      phase_next            = plmc_pkg::PH_HEAD;
      byte_offset_next      = 33'd0;
      header_store_next     = 64'd0;
      declared_payload_next = 32'd0;
      declared_count_next   = 16'd0;
      paths_seen_next       = 16'd0;
      record_remaining_next = 32'd0;
      low_byte_hold_next    = 8'd0;
      first_error_next      = plmc_pkg::ERR_OK;
    end else begin
      phase_next            = phase_step;
      byte_offset_next      = byte_offset_step;
      header_store_next     = header_store_step;
      declared_payload_next = declared_payload_step;
      declared_count_next   = declared_count_step;
      paths_seen_next       = paths_seen_step;
      record_remaining_next = record_remaining_step;
      low_byte_hold_next    = low_byte_hold_step;
      first_error_next      = first_error_step;
    end
  end

  assign end_step = plmc_pkg::HEADER_BYTES + {1'b0, declared_payload_step};

  // results of this byte
  always_comb begin
    if (phase_step == plmc_pkg::PH_HEAD) begin
      verdict = plmc_pkg::ERR_SHORT;
    end else if (first_error_step inside {[plmc_pkg::ERR_MAGIC:plmc_pkg::ERR_PAYLOAD]}) begin
      verdict = first_error_step;
    end else if (byte_offset_step != end_step) begin
      verdict = plmc_pkg::ERR_SIZE;
    end else if (first_error_step != plmc_pkg::ERR_OK) begin
      verdict = first_error_step;
    end else if (phase_step != plmc_pkg::PH_TAIL) begin
      verdict = plmc_pkg::ERR_OVERRUN;
    end else begin
      verdict = plmc_pkg::ERR_OK;
    end

    prim_valid = ((phase == plmc_pkg::PH_LEN3) && !len_full[0] && !len3_over &&
                  (len_full == 32'd0)) ||
                 ((phase == plmc_pkg::PH_TEXT) && !text_low);

    prim.kind        = (phase == plmc_pkg::PH_TEXT) ? plmc_pkg::KIND_UNIT
                                                    : plmc_pkg::KIND_EMPTY;
    prim.code_unit   = (phase == plmc_pkg::PH_TEXT) ? {data_byte, low_byte_hold} : 16'd0;
    prim.path_done   = (phase == plmc_pkg::PH_TEXT) ? text_done : 1'b1;
    prim.path_number = paths_seen;
    prim.error_code  = plmc_pkg::ERR_OK;
    prim.last_of_run = ~end_of_message;

    vres.kind        = plmc_pkg::KIND_VERDICT;
    vres.code_unit   = 16'd0;
    vres.path_done   = 1'b0;
    vres.path_number = 16'd0;
    vres.error_code  = verdict;
    vres.last_of_run = 1'b1;

    res = {vres, vres};
    res_count = 2'd0;
    if (accept) begin
      if (prim_valid) begin
        res[0]    = prim;
        res[1]    = vres;
        res_count = end_of_message ? 2'd2 : 2'd1;
      end else if (end_of_message) begin
        res_count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= plmc_pkg::PH_HEAD;
      byte_offset      <= 33'd0;
      header_store     <= 64'd0;
      declared_payload <= 32'd0;
      declared_count   <= 16'd0;
      paths_seen       <= 16'd0;
      record_remaining <= 32'd0;
      low_byte_hold    <= 8'd0;
      first_error      <= plmc_pkg::ERR_OK;
    end else if (accept) begin
      phase            <= phase_next;
      byte_offset      <= byte_offset_next;
      header_store     <= header_store_next;
      declared_payload <= declared_payload_next;
      declared_count   <= declared_count_next;
      paths_seen       <= paths_seen_next;
      record_remaining <= record_remaining_next;
      low_byte_hold    <= low_byte_hold_next;
      first_error      <= first_error_next;
    end
  end

endmodule

// ----- hw/rtl/plmc_queue.sv -----
module plmc_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               push_count,
  input  plmc_pkg::result_t [1:0]  push_data,
  input  logic                     pop,
  output logic                     out_valid,
  output plmc_pkg::result_t        out_data,
  output plmc_pkg::queue_status_t  status
);

  plmc_pkg::result_t mem [plmc_pkg::QUEUE_DEPTH];
  logic [plmc_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [plmc_pkg::QUEUE_AW:0]   count, count_next;
  logic                          do_pop;

  assign out_valid    = (count != '0);
  assign out_data     = mem[rd_ptr];
  assign do_pop       = pop & out_valid;
  assign count_next   = count + {1'b0, push_count} - {{plmc_pkg::QUEUE_AW{1'b0}}, do_pop};
  // two free slots cover the largest burst from one item
  assign status.room2 = (count <= (plmc_pkg::QUEUE_AW + 1)'(plmc_pkg::QUEUE_DEPTH - 2));
  assign status.count = count;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_data[0];
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count[plmc_pkg::QUEUE_AW-1:0];
      rd_ptr <= rd_ptr + {{(plmc_pkg::QUEUE_AW-1){1'b0}}, do_pop};
      count  <= count_next;
    end
  end

endmodule
